[src/ratree_pkg.sv]
// Shared types, codes and helpers for the range assign / range max tree.
// No dependencies; imported by the tree core, the checker and the testbench.
package ratree_pkg;

	localparam int unsigned LEAVES_DEF = 1024;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned POS_W = 11;
	// node word: {pending valid, pending assign, subtree max}
	localparam int unsigned WORD_W = 2 * VAL_W + 1;

	localparam logic [1:0] REQ_ASSIGN = 2'd0;
	localparam logic [1:0] REQ_ADD    = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	// frame phase: just entered, left child returned, right child returned
	localparam logic [1:0] PH_ENTER = 2'd0;
	localparam logic [1:0] PH_LEFT  = 2'd1;
	localparam logic [1:0] PH_RIGHT = 2'd2;

	localparam logic signed [VAL_W-1:0] EMPTY_MAX = -32'sd10000;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_ENTER, S_NODE, S_PD1, S_PD2, S_PD3,
		S_CHILD, S_PULL1, S_PULL2, S_PULL3, S_OUT
	} state_t;

	function automatic logic signed [VAL_W-1:0] smax(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b);
		return (a >= b) ? a : b;
	endfunction

endpackage

[src/ratree_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ratree_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/range_assign_max_segment_tree.sv]
// Top level: lazy assign / max segment tree sequencer over one node RAM.
// Depends on ratree_pkg and ratree_ram.
//
//  channel | signals                                          | dir
//  in      | in_valid in_stall req_type range_lo range_hi      | to block
//          | operand_value                                    |
//  out     | out_valid out_stall max_value range_empty        | from block
//
// After reset a clearing pass writes all 4*LEAVES node words, one a cycle, with the input stalled.
// Going down a level passes S_ENTER, S_NODE and S_CHILD, with S_PD1 to S_PD3 between to push a
// pending tag; a return re-enters S_ENTER, a pull-up adds S_PULL1 to S_PULL3, and a leaf or covered
// node ends its frame in S_ENTER or S_NODE, all set by the single RAM port pair. An empty query
// skips the walk and goes from S_IDLE straight to S_OUT.
// A query result waits in an output register while the next request is taken; a later result
// holds, with the input stalled, until that register is free.
module range_assign_max_segment_tree #(
	parameter int unsigned LEAVES = ratree_pkg::LEAVES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            req_type,
	input  logic [ratree_pkg::POS_W-1:0]          range_lo,
	input  logic [ratree_pkg::POS_W-1:0]          range_hi,
	input  logic signed [ratree_pkg::VAL_W-1:0]   operand_value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [ratree_pkg::VAL_W-1:0]   max_value,
	output logic                                  range_empty
);
	import ratree_pkg::*;

	localparam int unsigned NODES = 4 * LEAVES;
	localparam int unsigned NW    = $clog2(NODES);
	localparam int unsigned PW    = $clog2(LEAVES + 1);
	localparam int unsigned DEPTH = $clog2(LEAVES) + 1;
	localparam int unsigned SPW   = $clog2(DEPTH);
	localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);
	localparam logic [PW-1:0] LEAF_HI   = PW'(LEAVES);

	state_t state_q, state_d;

	// frame stack
	logic [NW-1:0]           n_q    [DEPTH];
	logic [PW-1:0]           l_q    [DEPTH];
	logic [PW-1:0]           r_q    [DEPTH];
	logic [1:0]              ph_q   [DEPTH];
	logic signed [VAL_W-1:0] best_q [DEPTH];
	logic                    any_q  [DEPTH];
	logic [SPW-1:0]          sp_q;

	logic [1:0]              op_q;
	logic [PW-1:0]           x_q, y_q;
	logic signed [VAL_W-1:0] v_q, ret_q, left_q;
	logic                    empty_q;
	logic [WORD_W-1:0]       node_q;
	logic [NW-1:0]           clr_q;

	// output register
	logic                    res_valid_q, res_empty_q, out_load;
	logic signed [VAL_W-1:0] res_max_q;

	// RAM port
	logic              we;
	logic [NW-1:0]     waddr, raddr;
	logic [WORD_W-1:0] wdata, rdata;

	ratree_ram #(.WIDTH(WORD_W), .DEPTH(NODES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// top frame view
	logic [NW-1:0]           tn, c0, c1;
	logic [PW-1:0]           tl, tr, mid, mid1;
	logic [PW:0]             lr_sum;
	logic [1:0]              tph;
	logic signed [VAL_W-1:0] tbest, rd_max, nd_max, nd_asg;
	logic                    tany, covered, overlap, go_left;
	logic [SPW-1:0]          sp_up;

	assign tn     = n_q[sp_q];
	assign tl     = l_q[sp_q];
	assign tr     = r_q[sp_q];
	assign tph    = ph_q[sp_q];
	assign tbest  = best_q[sp_q];
	assign tany   = any_q[sp_q];
	assign c0     = {tn[NW-2:0], 1'b0};
	assign c1     = {tn[NW-2:0], 1'b1};
	assign lr_sum = {1'b0, tl} + {1'b0, tr};
	assign mid    = lr_sum[PW:1];
	assign mid1   = mid + 1'b1;
	assign sp_up  = sp_q + 1'b1;
	assign covered = (x_q <= tl) && (tr <= y_q);
	assign overlap = !((tl > y_q) || (x_q > tr));
	assign go_left = (op_q == REQ_ASSIGN) || (x_q <= mid);
	assign rd_max  = rdata[VAL_W-1:0];
	assign nd_max  = node_q[VAL_W-1:0];
	assign nd_asg  = node_q[2*VAL_W-1:VAL_W];

	// walk decisions
	logic ent0, ent1, ent2, asg_done, q_cov, add_leaf;
	logic pop_now, push_now, push_right, pull_now;

	assign ent0     = (state_q == S_ENTER) && (tph == PH_ENTER);
	assign ent1     = (state_q == S_ENTER) && (tph == PH_LEFT);
	assign ent2     = (state_q == S_ENTER) && (tph == PH_RIGHT);
	assign asg_done = (op_q == REQ_ASSIGN) && (!overlap || covered);
	assign q_cov    = (state_q == S_NODE) && (op_q == REQ_QUERY) && covered;
	assign add_leaf = (state_q == S_NODE) && (op_q == REQ_ADD) && (tl == tr);
	assign pop_now  = (ent0 && asg_done) ||
		(ent1 && (op_q == REQ_QUERY) && !(y_q > mid)) ||
		(ent2 && (op_q == REQ_QUERY)) || q_cov || add_leaf ||
		(state_q == S_PULL3);
	assign push_now = (state_q == S_CHILD) ||
		(ent1 && ((op_q == REQ_ASSIGN) || ((op_q == REQ_QUERY) && (y_q > mid))));
	assign push_right = (state_q == S_CHILD) ? !go_left : 1'b1;
	assign pull_now = (ent1 && (op_q == REQ_ADD)) ||
		(ent2 && (op_q != REQ_QUERY));

	// move a finished result into the output register once it is free
	assign out_load = (state_q == S_OUT) && (!res_valid_q || !out_stall);

	// request decode with range clipping
	logic [31:0] lo_c, hi_c;
	logic        in_xfer, start, q_empty;

	assign in_xfer = in_valid && !in_stall;
	always_comb begin
		lo_c = (range_lo == '0) ? 32'd1 : 32'(range_lo);
		hi_c = (32'(range_hi) > LEAVES) ? LEAVES : 32'(range_hi);
		q_empty = (req_type == REQ_QUERY) && (lo_c > hi_c);
		unique case (req_type)
			REQ_ADD:    start = (range_lo != '0) && (32'(range_lo) <= LEAVES);
			REQ_ASSIGN: start = (lo_c <= hi_c);
			REQ_QUERY:  start = (lo_c <= hi_c);
			default:    start = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == LAST_NODE) state_d = S_IDLE;
			S_IDLE: begin
				if (in_xfer && start) state_d = S_ENTER;
				else if (in_xfer && q_empty) state_d = S_OUT;
			end
			S_ENTER, S_NODE, S_PULL3: begin
				if (pop_now) begin
					if (sp_q != '0) state_d = S_ENTER;
					else if (op_q == REQ_QUERY) state_d = S_OUT;
					else state_d = S_IDLE;
				end else if (push_now) begin
					state_d = S_ENTER;
				end else if (pull_now) begin
					state_d = S_PULL1;
				end else if (state_q == S_ENTER) begin
					state_d = S_NODE;
				end else begin
					state_d = rdata[WORD_W-1] ? S_PD1 : S_CHILD;
				end
			end
			S_PD1:   state_d = S_PD2;
			S_PD2:   state_d = S_PD3;
			S_PD3:   state_d = S_CHILD;
			S_CHILD: state_d = S_ENTER;
			S_PULL1: state_d = S_PULL2;
			S_PULL2: state_d = S_PULL3;
			S_OUT:   if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// RAM controls and handshake outputs
	always_comb begin
		we    = 1'b0;
		waddr = tn;
		wdata = '0;
		raddr = tn;
		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			S_ENTER: begin
				if (tph == PH_ENTER && op_q == REQ_ASSIGN && overlap && covered) begin
					we    = 1'b1;
					wdata = {1'b1, v_q, v_q};
				end
			end
			S_NODE: begin
				if (add_leaf) begin
					we    = 1'b1;
					wdata = {rdata[WORD_W-1:VAL_W], rd_max + v_q};
				end
			end
			S_PD1: begin
				we    = 1'b1;
				waddr = c0;
				wdata = {1'b1, nd_asg, nd_asg};
			end
			S_PD2: begin
				we    = 1'b1;
				waddr = c1;
				wdata = {1'b1, nd_asg, nd_asg};
			end
			S_PD3: begin
				we    = 1'b1;
				wdata = {1'b0, nd_asg, nd_max};
			end
			S_PULL1: raddr = c0;
			S_PULL2: raddr = c1;
			S_PULL3: begin
				we    = 1'b1;
				wdata = {1'b0, {VAL_W{1'b0}}, smax(left_q, rd_max)};
			end
			default: ;
		endcase
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = res_valid_q;
	assign max_value   = res_max_q;
	assign range_empty = res_empty_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			sp_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == S_IDLE) sp_q <= '0;
			else if (pop_now && sp_q != '0) sp_q <= sp_q - 1'b1;
			else if (push_now) sp_q <= sp_up;
			if (out_load) res_valid_q <= 1'b1;
			else if (!out_stall) res_valid_q <= 1'b0;
		end
	end

	// datapath: request, frames, return value
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_xfer) begin
			op_q     <= req_type;
			x_q      <= PW'(lo_c);
			y_q      <= PW'(hi_c);
			v_q      <= operand_value;
			empty_q  <= q_empty;
			ret_q    <= EMPTY_MAX;
			n_q[0]   <= NW'(1);
			l_q[0]   <= PW'(1);
			r_q[0]   <= LEAF_HI;
			ph_q[0]  <= PH_ENTER;
			any_q[0] <= 1'b0;
		end
		if (state_q == S_NODE) node_q <= rdata;
		if (state_q == S_PULL2) left_q <= rd_max;
		// collect child results
		if (q_cov) ret_q <= rd_max;
		if (ent1 && op_q == REQ_QUERY) begin
			best_q[sp_q] <= ret_q;
			any_q[sp_q]  <= 1'b1;
		end
		if (ent2 && op_q == REQ_QUERY && tany) ret_q <= smax(tbest, ret_q);
		// open child frame
		if (push_now) begin
			ph_q[sp_q]    <= push_right ? PH_RIGHT : PH_LEFT;
			n_q[sp_up]    <= push_right ? c1 : c0;
			l_q[sp_up]    <= push_right ? mid1 : tl;
			r_q[sp_up]    <= push_right ? tr : mid;
			ph_q[sp_up]   <= PH_ENTER;
			any_q[sp_up]  <= 1'b0;
		end
		// load the output register
		if (out_load) begin
			res_max_q   <= ret_q;
			res_empty_q <= empty_q;
		end
	end
endmodule

[src/ratree_checker.sv]
// Port-level checks for the range assign / range max tree.
// Depends on ratree_pkg; bound to range_assign_max_segment_tree below.
module ratree_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic [1:0]                          req_type,
	input logic [ratree_pkg::POS_W-1:0]        range_lo,
	input logic [ratree_pkg::POS_W-1:0]        range_hi,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [ratree_pkg::VAL_W-1:0] max_value,
	input logic                                range_empty
);
	import ratree_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(max_value) && $stable(range_empty))
		else $error("stalled result changed");

	// empty flag carries the empty marker value
	a_empty_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_empty |-> max_value == EMPTY_MAX)
		else $error("empty result with wrong value");

	// empty query with the output free is answered with the empty flag set
	a_empty_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid && req_type == REQ_QUERY &&
		range_lo > range_hi |-> ##2 out_valid && range_empty)
		else $error("empty query not answered");
endmodule

bind range_assign_max_segment_tree ratree_checker u_ratree_checker (.*);

[sim/tb_range_assign_max_segment_tree.sv]
// Testbench for the range assign / range max segment tree: directed and random
// requests checked against a flat-array predictor. Depends on ratree_pkg and the RTL.
module tb_range_assign_max_segment_tree;
	timeunit 1ns;
	timeprecision 1ps;
	import ratree_pkg::*;

	localparam int unsigned NPOS = 1024;
	localparam int WATCHDOG = 200000;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	class max_scoreboard;
		logic signed [31:0] cells[1:NPOS];
		logic signed [31:0] want_max[$];
		logic want_empty[$];
		int errors;

		function void clear_cells();
			for (int i = 1; i <= NPOS; i++) cells[i] = 0;
			errors = 0;
		endfunction

		// apply one accepted request to the array; queue a result for queries
		function void note_request(logic [1:0] kind, logic [10:0] lo, logic [10:0] hi,
				logic signed [31:0] v);
			int l, h;
			logic signed [31:0] best;
			l = lo;
			h = hi;
			if (kind == REQ_ADD) begin
				if (l >= 1 && l <= NPOS) cells[l] = cells[l] + v;
				return;
			end
			if (l < 1) l = 1;
			if (h > NPOS) h = NPOS;
			if (kind == REQ_ASSIGN) begin
				for (int i = l; i <= h; i++) cells[i] = v;
			end else if (kind == REQ_QUERY) begin
				if (l > h) begin
					want_max = {want_max, EMPTY_MAX};
					want_empty = {want_empty, 1'b1};
				end else begin
					best = cells[l];
					for (int i = l + 1; i <= h; i++) if (cells[i] > best) best = cells[i];
					want_max = {want_max, best};
					want_empty = {want_empty, 1'b0};
				end
			end
		endfunction

		function void check_result(logic signed [31:0] mx, logic emp);
			logic signed [31:0] em;
			logic ee;
			if (want_max.size() == 0) begin
				$error("unexpected result max_value=%0d range_empty=%0b", mx, emp);
				errors++;
				return;
			end
			em = want_max.pop_front();
			ee = want_empty.pop_front();
			if (mx !== em) begin
				$error("max_value expected %0d actual %0d", em, mx);
				errors++;
			end
			if (emp !== ee) begin
				$error("range_empty expected %0b actual %0b", ee, emp);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0, range_empty;
	logic [1:0] req_type = 0;
	logic [10:0] range_lo = 0, range_hi = 0;
	logic signed [31:0] operand_value = 0, max_value;

	int send_idle_pct = 0, recv_stall_pct = 0;
	bit hold_off = 0;
	int idle_cycles = 0;
	max_scoreboard board;

	range_assign_max_segment_tree dut (.*);

	initial forever #5 clk = ~clk;

	// sample both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) board.check_result(max_value, range_empty);
			if (in_valid && !in_stall) board.note_request(req_type, range_lo, range_hi,
				operand_value);
			if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// random stall on the result side, or a long hold-off
	always @(negedge clk)
		out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);

	// offer one request and hold it until its transfer
	task automatic send(logic [1:0] k, logic [10:0] lo, logic [10:0] hi, logic signed [31:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		req_type = k;
		range_lo = lo;
		range_hi = hi;
		operand_value = v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic drain();
		while (board.want_max.size() != 0) @(negedge clk);
	endtask

	function automatic logic [10:0] pick_pos();
		int r;
		r = $urandom_range(99);
		if (r < 4) return '0;
		if (r < 8) return 11'($urandom_range(2047, 1025));
		if (r < 30) return 11'($urandom_range(16, 1));
		if (r < 40) return 11'($urandom_range(1024, 1008));
		return 11'($urandom_range(1024, 1));
	endfunction

	function automatic logic signed [31:0] pick_val();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'($urandom_range(20, 0)) - 10;
			3: return -32'sd10000 - 32'($urandom_range(3));
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(int n);
		logic [1:0] k;
		logic [10:0] lo, hi, t;
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(49) == 0) ? REQ_UNUSED : 2'($urandom_range(2));
			lo = pick_pos();
			hi = pick_pos();
			// mostly ordered ranges, some reversed
			if (lo > hi && $urandom_range(9) != 0) begin
				t = lo; lo = hi; hi = t;
			end
			send(k, lo, hi, pick_val());
		end
	endtask

	initial begin
		board = new();
		board.clear_cells();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, every request kind, each special case
		send(REQ_QUERY, 1, 1024, 0);
		send(REQ_ASSIGN, 1, 1024, 32'sh80000000);
		send(REQ_QUERY, 1, 1024, 0);
		send(REQ_ASSIGN, 0, 2047, -32'sd20000);
		send(REQ_QUERY, 0, 2047, 0);
		send(REQ_ASSIGN, 5, 3, 7);
		send(REQ_QUERY, 600, 5, 0);
		send(REQ_QUERY, 1025, 2047, 0);
		send(REQ_ASSIGN, 2, 9, 0);
		send(REQ_ADD, 4, 0, 32'sh7fffffff);
		send(REQ_ADD, 4, 0, 1);
		send(REQ_QUERY, 1, 10, 0);
		send(REQ_ADD, 0, 5, 99);
		send(REQ_ADD, 1025, 5, 99);
		send(REQ_ADD, 2047, 2047, 32'shffffffff);
		send(REQ_UNUSED, 1, 1024, 55);
		send(REQ_ASSIGN, 1024, 1024, 32'sh7fffffff);
		send(REQ_ADD, 1024, 1, 32'sh80000000);
		send(REQ_QUERY, 1000, 1024, 0);
		send(REQ_QUERY, 1, 1, 0);
		send(REQ_ASSIGN, 1, 512, 32'sh55555555);
		send(REQ_ASSIGN, 513, 1024, 32'shaaaaaaaa);
		send(REQ_QUERY, 512, 513, 0);
		send(REQ_ADD, 1023, 1, -32'sd5);
		send(REQ_QUERY, 1023, 1023, 0);

		random_phase(450);
		send_idle_pct = 65;
		random_phase(400);
		send_idle_pct = 0;
		recv_stall_pct = 65;
		random_phase(400);
		// long receiver hold-off while the sender keeps offering
		fork
			begin
				hold_off = 1;
				repeat (3000) @(negedge clk);
				hold_off = 0;
			end
			random_phase(40);
		join
		// pause until every result is back
		drain();
		send_idle_pct = 31;
		recv_stall_pct = 31;
		random_phase(330);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_phase(300);

		drain();
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.want_max.size() == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
